@@ src/rtc3w_pkg.sv @@
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Shared types, codes and BCD helpers for the three-wire RTC time master.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    // action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam int unsigned NUM_FIELDS = 7;

    localparam logic [3:0] WRITE_XFERS    = 4'd9;
    localparam logic [3:0] READ_XFERS     = 4'd7;
    localparam logic [3:0] LAST_FIELD_IDX = 4'd7;   // read transfers below this carry a field
    localparam logic [3:0] WP_ON_XFER     = 4'd8;
    localparam logic [3:0] FIRST_RD_BIT   = 4'd8;
    localparam logic [3:0] LAST_BIT       = 4'd15;
    localparam logic [1:0] PH_LOW         = 2'd0;
    localparam logic [1:0] PH_HIGH        = 2'd1;
    localparam logic [1:0] PH_GAP         = 2'd2;

    localparam logic [7:0] WP_ADDR  = 8'h8E;
    localparam logic [7:0] WP_OFF   = 8'h00;
    localparam logic [7:0] WP_ON    = 8'h80;
    localparam logic [7:0] READ_BIT = 8'h01;

    // year, month, date, hour, minute, second, weekday
    typedef logic [NUM_FIELDS-1:0][7:0] tod_t;

    function automatic logic [7:0] reg_addr(input logic [2:0] idx);
        logic [7:0] a;
        case (idx)
            3'd0:    a = 8'h8C;
            3'd1:    a = 8'h88;
            3'd2:    a = 8'h86;
            3'd3:    a = 8'h84;
            3'd4:    a = 8'h82;
            3'd5:    a = 8'h80;
            3'd6:    a = 8'h8A;
            default: a = 8'h8C;
        endcase
        return a;
    endfunction

    // v/10 by reciprocal 205/2048, exact for 0..127
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = {8'd0, v} * 15'd205;
        q    = prod[14:11];
        r    = v - ({q, 3'b000} + {2'b00, q, 1'b0});
        return {q, r[3:0]};
    endfunction

    // unmasked decode: hi*10 + lo, 0..165
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        logic [7:0] hi10;
        hi10 = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
        return hi10 + {4'b0000, b[3:0]};
    endfunction

endpackage

@@ src/rtc3w_time_enc.sv @@
// ----------------------------------------------------------------------------
// rtc3w_time_enc
// Converts the seven decimal time fields to BCD bytes in register order.
// ----------------------------------------------------------------------------
module rtc3w_time_enc (
    input  logic [6:0]      year_i,
    input  logic [3:0]      month_i,
    input  logic [4:0]      date_i,
    input  logic [4:0]      hour_i,
    input  logic [5:0]      minute_i,
    input  logic [5:0]      second_i,
    input  logic [2:0]      weekday_i,
    output rtc3w_pkg::tod_t bcd_o
);
    import rtc3w_pkg::*;

    always_comb begin
        bcd_o[0] = to_bcd(year_i);
        bcd_o[1] = to_bcd({3'b000, month_i});
        bcd_o[2] = to_bcd({2'b00, date_i});
        bcd_o[3] = to_bcd({2'b00, hour_i});
        bcd_o[4] = to_bcd({1'b0, minute_i});
        bcd_o[5] = to_bcd({1'b0, second_i});
        bcd_o[6] = to_bcd({4'b0000, weekday_i});
    end

endmodule

@@ src/rtc_three_wire_time_master.sv @@
// ----------------------------------------------------------------------------
// rtc_three_wire_time_master
// Bit-serial master for a three-wire RTC: writes or reads the time registers
// one pin phase per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | action, io_in, decimal time fields
//  m_      | out       | m_valid / m_ready  | pin levels, finished, last read time
//
//  One item in, one result out; a new item is taken every
//  cycle while the result register is empty or being emptied.
//  The sequencer advances only on an accepted item, so stalls on either side
//  just freeze the pin sequence.
//  Reset (aresetn low, synchronous) returns the sequencer to idle, clears the
//  last read time and empties the result register.
// ----------------------------------------------------------------------------
module rtc_three_wire_time_master (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic       s_io_in,
    input  logic [6:0] s_year_in,
    input  logic [3:0] s_month_in,
    input  logic [4:0] s_date_in,
    input  logic [4:0] s_hour_in,
    input  logic [5:0] s_minute_in,
    input  logic [5:0] s_second_in,
    input  logic [2:0] s_weekday_in,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_clock_pin,
    output logic       m_enable_pin,
    output logic       m_data_out,
    output logic       m_data_drive,
    output logic       m_finished,
    output logic [7:0] m_year_out,
    output logic [7:0] m_month_out,
    output logic [7:0] m_date_out,
    output logic [7:0] m_hour_out,
    output logic [7:0] m_minute_out,
    output logic [7:0] m_second_out,
    output logic [7:0] m_weekday_out
);
    import rtc3w_pkg::*;

    // sequencer state
    mode_t       mode_reg,  mode_next;
    logic [3:0]  tidx_reg,  tidx_next;
    logic [3:0]  bit_reg,   bit_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] shift_reg, shift_next;
    tod_t        pend_reg,  pend_next;   // BCD bytes to write, no reset
    tod_t        rtime_reg, rtime_next;  // decoded last read

    // result register
    logic        m_valid_reg, m_valid_next;
    logic        clk_reg, en_reg, dout_reg, drive_reg, fin_reg;
    tod_t        rout_reg;

    logic        clk_next, en_next, dout_next, drive_next, fin_next;

    logic        accept;
    logic        start_wr, start_rd;
    mode_t       cur_mode;
    logic [3:0]  cur_t, cur_b, t_inc, xfers;
    logic [1:0]  cur_ph;
    logic        busy, gap, reading, last_xfer;
    logic [2:0]  fidx;
    logic [15:0] load_word, word;
    tod_t        bcd;

    rtc3w_time_enc u_enc (
        .year_i    (s_year_in),
        .month_i   (s_month_in),
        .date_i    (s_date_in),
        .hour_i    (s_hour_in),
        .minute_i  (s_minute_in),
        .second_i  (s_second_in),
        .weekday_i (s_weekday_in),
        .bcd_o     (bcd)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Start is taken only from idle; the start tick already shows bit 0.
    always_comb begin
        start_wr = (mode_reg == MODE_IDLE) && (s_action == ACT_WRITE);
        start_rd = (mode_reg == MODE_IDLE) && (s_action == ACT_READ);
        if (start_wr) begin
            cur_mode = MODE_WRITE;
        end else if (start_rd) begin
            cur_mode = MODE_READ;
        end else begin
            cur_mode = mode_reg;
        end
        cur_t   = (start_wr || start_rd) ? 4'd0 : tidx_reg;
        cur_b   = (start_wr || start_rd) ? 4'd0 : bit_reg;
        cur_ph  = (start_wr || start_rd) ? PH_LOW : phase_reg;
        busy    = (cur_mode == MODE_WRITE) || (cur_mode == MODE_READ);
        gap     = (cur_ph >= PH_GAP);
        reading = (cur_mode == MODE_READ) && (cur_b >= FIRST_RD_BIT);
        t_inc   = cur_t + 4'd1;
        xfers   = (cur_mode == MODE_WRITE) ? WRITE_XFERS : READ_XFERS;
        last_xfer = (t_inc >= xfers);

        // command/data pair for the transfer about to start
        fidx = 3'(cur_t - 4'd1);
        if (cur_mode == MODE_WRITE) begin
            if (cur_t == 4'd0) begin
                load_word = {WP_OFF, WP_ADDR};
            end else if (cur_t >= WP_ON_XFER) begin
                load_word = {WP_ON, WP_ADDR};
            end else begin
                load_word = {pend_reg[fidx], reg_addr(fidx)};
            end
        end else begin
            load_word = {8'h00,
                         reg_addr((cur_t < LAST_FIELD_IDX) ? cur_t[2:0] : 3'd0) | READ_BIT};
        end
        word = ((cur_b == 4'd0) && (cur_ph == PH_LOW)) ? load_word : shift_reg;
    end

    // next state
    always_comb begin
        mode_next  = cur_mode;
        tidx_next  = cur_t;
        bit_next   = cur_b;
        phase_next = cur_ph;
        shift_next = shift_reg;
        rtime_next = rtime_reg;
        pend_next  = start_wr ? bcd : pend_reg;
        if (busy) begin
            if (gap) begin
                if ((cur_mode == MODE_READ) && (cur_t < LAST_FIELD_IDX)) begin
                    rtime_next[cur_t[2:0]] = from_bcd(shift_reg[15:8]);
                end
                tidx_next  = t_inc;
                bit_next   = 4'd0;
                phase_next = PH_LOW;
                if (last_xfer) begin
                    mode_next = MODE_IDLE;
                    tidx_next = 4'd0;
                end
            end else begin
                shift_next = word;
                // sample after the falling edge
                if (reading && (cur_ph == PH_HIGH) && s_io_in) begin
                    shift_next[cur_b] = 1'b1;
                end
                if (cur_ph == PH_LOW) begin
                    phase_next = PH_HIGH;
                end else if (cur_b >= LAST_BIT) begin
                    phase_next = PH_GAP;
                end else begin
                    phase_next = PH_LOW;
                    bit_next   = cur_b + 4'd1;
                end
            end
        end
    end

    // pin levels for this item
    always_comb begin
        clk_next   = 1'b0;
        en_next    = 1'b0;
        dout_next  = 1'b0;
        drive_next = 1'b1;
        fin_next   = 1'b0;
        if (busy) begin
            if (gap) begin
                fin_next = last_xfer;
            end else begin
                en_next = 1'b1;
                if (reading) begin
                    // released line: clock high then low
                    drive_next = 1'b0;
                    clk_next   = (cur_ph == PH_LOW);
                end else begin
                    dout_next = word[cur_b];
                    clk_next  = cur_ph[0];
                end
            end
        end
    end

    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            tidx_reg    <= 4'd0;
            bit_reg     <= 4'd0;
            phase_reg   <= PH_LOW;
            shift_reg   <= 16'd0;
            rtime_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                mode_reg  <= mode_next;
                tidx_reg  <= tidx_next;
                bit_reg   <= bit_next;
                phase_reg <= phase_next;
                shift_reg <= shift_next;
                rtime_reg <= rtime_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg  <= pend_next;
            clk_reg   <= clk_next;
            en_reg    <= en_next;
            dout_reg  <= dout_next;
            drive_reg <= drive_next;
            fin_reg   <= fin_next;
            rout_reg  <= rtime_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_clock_pin   = clk_reg;
    assign m_enable_pin  = en_reg;
    assign m_data_out    = dout_reg;
    assign m_data_drive  = drive_reg;
    assign m_finished    = fin_reg;
    assign m_year_out    = rout_reg[0];
    assign m_month_out   = rout_reg[1];
    assign m_date_out    = rout_reg[2];
    assign m_hour_out    = rout_reg[3];
    assign m_minute_out  = rout_reg[4];
    assign m_second_out  = rout_reg[5];
    assign m_weekday_out = rout_reg[6];

    // idle sequencer always sits at the start of a transfer
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE) |-> (phase_reg == PH_LOW && bit_reg == 4'd0 && tidx_reg == 4'd0))
        else $error("idle with stale sequencer counters");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("clock phase out of range");

    a_tidx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((mode_reg == MODE_READ) |-> (tidx_reg < READ_XFERS)) and
        ((mode_reg == MODE_WRITE) |-> (tidx_reg < WRITE_XFERS)))
        else $error("transfer index beyond request length");

    a_fin_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && fin_reg) |-> (!en_reg && !clk_reg && drive_reg && !dout_reg))
        else $error("finished item not on a gap tick");

endmodule

@@ test/tb_rtc_three_wire_time_master.sv @@
// ----------------------------------------------------------------------------
// tb_rtc_three_wire_time_master
// Self-checking bench for the three-wire RTC time master. Whole write-time and
// read-time requests, idle ticks and stray actions are sent as one item per
// tick. A local model of the pin sequencer predicts every result item, which
// is checked field by field in arrival order. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_rtc_three_wire_time_master;
    timeunit 1ns;
    timeprecision 1ps;

    import rtc3w_pkg::*;

    // spare action code, behaves as a plain tick
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // every transfer is 16 bits of two ticks each plus one gap tick
    localparam int unsigned TICKS_PER_XFER = 33;

    // data line level policy for the ticks of a request
    localparam int unsigned IO_LOW  = 0;
    localparam int unsigned IO_HIGH = 1;
    localparam int unsigned IO_RAND = 2;

    localparam int unsigned TOTAL_ITEMS = 600;

    // stretch of cycles with no idling on either side
    localparam int unsigned QUIET_FROM = 250;
    localparam int unsigned QUIET_TO   = 450;

    // chip register addresses: year, month, date, hour, minute, second, weekday
    localparam logic [7:0] TOD_ADDR [NUM_FIELDS] =
        '{8'h8C, 8'h88, 8'h86, 8'h84, 8'h82, 8'h80, 8'h8A};

    typedef struct packed {
        logic [1:0] action;
        logic       io;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } tick_item_t;

    typedef struct packed {
        logic clk;
        logic en;
        logic dout;
        logic drive;
        logic fin;
        tod_t tod;
    } pin_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [1:0] s_action     = ACT_TICK;
    logic       s_io_in      = 1'b0;
    logic [6:0] s_year_in    = '0;
    logic [3:0] s_month_in   = '0;
    logic [4:0] s_date_in    = '0;
    logic [4:0] s_hour_in    = '0;
    logic [5:0] s_minute_in  = '0;
    logic [5:0] s_second_in  = '0;
    logic [2:0] s_weekday_in = '0;

    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic       m_clock_pin;
    logic       m_enable_pin;
    logic       m_data_out;
    logic       m_data_drive;
    logic       m_finished;
    logic [7:0] m_year_out;
    logic [7:0] m_month_out;
    logic [7:0] m_date_out;
    logic [7:0] m_hour_out;
    logic [7:0] m_minute_out;
    logic [7:0] m_second_out;
    logic [7:0] m_weekday_out;

    // ticks waiting to be driven, and the pin results they are due to produce
    tick_item_t  tick_q[$];
    pin_result_t pin_expect_q[$];
    tick_item_t  drv_item;

    int unsigned cyc      = 0;
    int unsigned n_errors = 0;

    string tod_name [NUM_FIELDS] =
        '{"year", "month", "date", "hour", "minute", "second", "weekday"};

    // sequencer model state
    mode_t       seq_mode    = MODE_IDLE;
    logic [3:0]  seq_xfer    = '0;
    logic [3:0]  seq_bit     = '0;
    logic [1:0]  seq_phase   = PH_LOW;
    logic [15:0] seq_shift   = '0;
    tod_t        seq_pending = '0;
    tod_t        seq_time    = '0;

    rtc_three_wire_time_master u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_io_in       (s_io_in),
        .s_year_in     (s_year_in),
        .s_month_in    (s_month_in),
        .s_date_in     (s_date_in),
        .s_hour_in     (s_hour_in),
        .s_minute_in   (s_minute_in),
        .s_second_in   (s_second_in),
        .s_weekday_in  (s_weekday_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_clock_pin   (m_clock_pin),
        .m_enable_pin  (m_enable_pin),
        .m_data_out    (m_data_out),
        .m_data_drive  (m_data_drive),
        .m_finished    (m_finished),
        .m_year_out    (m_year_out),
        .m_month_out   (m_month_out),
        .m_date_out    (m_date_out),
        .m_hour_out    (m_hour_out),
        .m_minute_out  (m_minute_out),
        .m_second_out  (m_second_out),
        .m_weekday_out (m_weekday_out)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) cyc <= cyc + 1;

    // ------------------------------------------------------------------------
    // Model of the sequencer
    // ------------------------------------------------------------------------

    // decimal to BCD, out-of-range values wrap to 8 bits
    function automatic logic [7:0] dec_to_bcd(input int unsigned v);
        int unsigned packed_val;
        packed_val = (v / 10) * 16 + (v % 10);
        return packed_val[7:0];
    endfunction

    // BCD to decimal with no masking, so nibbles above 9 are kept
    function automatic logic [7:0] bcd_to_dec(input logic [7:0] b);
        int unsigned dec_val;
        dec_val = int'(b[7:4]) * 10 + int'(b[3:0]);
        return dec_val[7:0];
    endfunction

    // command byte in the low half, data byte in the high half, LSB first
    function automatic logic [15:0] frame_for_xfer();
        logic [15:0] w;
        if (seq_mode == MODE_WRITE) begin
            if (seq_xfer == 4'd0)
                w = {WP_OFF, WP_ADDR};
            else if (seq_xfer >= WP_ON_XFER)
                w = {WP_ON, WP_ADDR};
            else
                w = {seq_pending[seq_xfer - 1], TOD_ADDR[seq_xfer - 1]};
        end else begin
            w = {8'h00, TOD_ADDR[(seq_xfer < LAST_FIELD_IDX) ? seq_xfer : 0] | READ_BIT};
        end
        return w;
    endfunction

    // advance the model by one accepted tick and return the pin result
    function automatic pin_result_t step_sequencer(input tick_item_t it);
        pin_result_t r;
        logic [3:0]  b;
        logic [3:0]  n_xfers;
        logic        reading;
        r.clk   = 1'b0;
        r.en    = 1'b0;
        r.dout  = 1'b0;
        r.drive = 1'b1;
        r.fin   = 1'b0;

        // a start is only taken while idle
        if (seq_mode == MODE_IDLE && (it.action == ACT_WRITE || it.action == ACT_READ)) begin
            if (it.action == ACT_WRITE) begin
                seq_pending[0] = dec_to_bcd(it.year);
                seq_pending[1] = dec_to_bcd(it.month);
                seq_pending[2] = dec_to_bcd(it.date);
                seq_pending[3] = dec_to_bcd(it.hour);
                seq_pending[4] = dec_to_bcd(it.minute);
                seq_pending[5] = dec_to_bcd(it.second);
                seq_pending[6] = dec_to_bcd(it.weekday);
                seq_mode = MODE_WRITE;
            end else begin
                seq_mode = MODE_READ;
            end
            seq_xfer  = '0;
            seq_bit   = '0;
            seq_phase = PH_LOW;
        end

        if (seq_mode != MODE_IDLE) begin
            if (seq_phase >= PH_GAP) begin
                // gap tick: chip enable low, read byte decoded
                n_xfers = (seq_mode == MODE_WRITE) ? WRITE_XFERS : READ_XFERS;
                if (seq_mode == MODE_READ && seq_xfer < LAST_FIELD_IDX)
                    seq_time[seq_xfer] = bcd_to_dec(seq_shift[15:8]);
                seq_xfer  = seq_xfer + 1'b1;
                seq_bit   = '0;
                seq_phase = PH_LOW;
                if (seq_xfer >= n_xfers) begin
                    r.fin    = 1'b1;
                    seq_mode = MODE_IDLE;
                    seq_xfer = '0;
                end
            end else begin
                b = seq_bit;
                if (b == 4'd0 && seq_phase == PH_LOW)
                    seq_shift = frame_for_xfer();
                r.en = 1'b1;
                reading = (seq_mode == MODE_READ) && (b >= FIRST_RD_BIT);
                if (!reading) begin
                    r.drive = 1'b1;
                    r.dout  = seq_shift[b];
                    r.clk   = seq_phase[0];
                end else begin
                    // line released, clock high then low, sample on the low tick
                    r.drive = 1'b0;
                    r.dout  = 1'b0;
                    r.clk   = (seq_phase == PH_LOW);
                    if (seq_phase == PH_HIGH && it.io)
                        seq_shift[b] = 1'b1;
                end
                if (seq_phase == PH_LOW) begin
                    seq_phase = PH_HIGH;
                end else if (b >= LAST_BIT) begin
                    seq_phase = PH_GAP;
                end else begin
                    seq_phase = PH_LOW;
                    seq_bit   = b + 1'b1;
                end
            end
        end

        r.tod = seq_time;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // time fields either in calendar range or anywhere in their width
    function automatic tick_item_t random_time(input bit full_width);
        tick_item_t t;
        t.action = ACT_TICK;
        t.io     = 1'($urandom_range(0, 1));
        if (full_width) begin
            t.year    = 7'($urandom);
            t.month   = 4'($urandom);
            t.date    = 5'($urandom);
            t.hour    = 5'($urandom);
            t.minute  = 6'($urandom);
            t.second  = 6'($urandom);
            t.weekday = 3'($urandom);
        end else begin
            t.year    = 7'($urandom_range(0, 99));
            t.month   = 4'($urandom_range(1, 12));
            t.date    = 5'($urandom_range(1, 31));
            t.hour    = 5'($urandom_range(0, 23));
            t.minute  = 6'($urandom_range(0, 59));
            t.second  = 6'($urandom_range(0, 59));
            t.weekday = 3'($urandom_range(1, 7));
        end
        return t;
    endfunction

    // start item plus exactly enough ticks to run the request to completion;
    // with busy_noise set, some of those ticks carry actions that must be ignored
    task automatic add_request(input logic [1:0] start_act, input tick_item_t t,
                               input int unsigned io_style, input bit busy_noise);
        int unsigned n_ticks;
        tick_item_t  x;
        n_ticks = ((start_act == ACT_WRITE) ? WRITE_XFERS : READ_XFERS) * TICKS_PER_XFER;
        t.action = start_act;
        tick_q.push_back(t);
        for (int unsigned i = 1; i < n_ticks; i++) begin
            x = random_time(1'b1);
            if (busy_noise && $urandom_range(0, 3) == 0)
                x.action = 2'($urandom_range(1, 3));
            case (io_style)
                IO_LOW:  x.io = 1'b0;
                IO_HIGH: x.io = 1'b1;
                default: x.io = 1'($urandom_range(0, 1));
            endcase
            tick_q.push_back(x);
        end
    endtask

    task automatic add_idle_tick(input logic [1:0] act, input logic io);
        tick_item_t x;
        x        = random_time(1'b1);
        x.action = act;
        x.io     = io;
        tick_q.push_back(x);
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, want, got);
            n_errors++;
        end
    endtask

    function automatic bit stall_now();
        return !(cyc >= QUIET_FROM && cyc < QUIET_TO) && ($urandom_range(0, 99) < 16);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one tick per accepted item, valid held until taken
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // item taken at this edge: run the model on it
            if (s_valid && s_ready)
                pin_expect_q.push_back(step_sequencer(drv_item));

            if (!s_valid || s_ready) begin
                if (tick_q.size() != 0 && !stall_now()) begin
                    drv_item     = tick_q.pop_front();
                    s_valid      <= 1'b1;
                    s_action     <= drv_item.action;
                    s_io_in      <= drv_item.io;
                    s_year_in    <= drv_item.year;
                    s_month_in   <= drv_item.month;
                    s_date_in    <= drv_item.date;
                    s_hour_in    <= drv_item.hour;
                    s_minute_in  <= drv_item.minute;
                    s_second_in  <= drv_item.second;
                    s_weekday_in <= drv_item.weekday;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        pin_result_t want;
        tod_t        got_tod;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pin_expect_q.size() == 0) begin
                    $display("%0t: result item with nothing predicted", $realtime);
                    n_errors++;
                end else begin
                    want = pin_expect_q.pop_front();
                    got_tod[0] = m_year_out;
                    got_tod[1] = m_month_out;
                    got_tod[2] = m_date_out;
                    got_tod[3] = m_hour_out;
                    got_tod[4] = m_minute_out;
                    got_tod[5] = m_second_out;
                    got_tod[6] = m_weekday_out;
                    check_field("clock_pin", want.clk, m_clock_pin);
                    check_field("enable_pin", want.en, m_enable_pin);
                    check_field("data_out", want.dout, m_data_out);
                    check_field("data_drive", want.drive, m_data_drive);
                    check_field("finished", want.fin, m_finished);
                    for (int k = 0; k < NUM_FIELDS; k++)
                        check_field({tod_name[k], "_out"}, want.tod[k], got_tod[k]);
                end
            end
            m_ready <= !stall_now();
        end
    end

    // ------------------------------------------------------------------------
    // Reset, stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        tick_item_t  t;

        // idle ticks, including the spare action code
        add_idle_tick(ACT_TICK, 1'b0);
        add_idle_tick(ACT_SPARE, 1'b1);
        add_idle_tick(ACT_TICK, 1'b1);
        add_idle_tick(ACT_SPARE, 1'b0);

        // write with every field bit set (out of range, BCD wraps), stray starts mid-request
        t = '1;
        add_request(ACT_WRITE, t, IO_RAND, 1'b1);

        // read of random data, nibbles above 9 decoded unmasked, stray starts mid-request
        add_request(ACT_READ, random_time(1'b1), IO_RAND, 1'b1);

        // idle noise up to the item budget
        while (tick_q.size() < TOTAL_ITEMS)
            add_idle_tick($urandom_range(0, 1) ? ACT_SPARE : ACT_TICK,
                          1'($urandom_range(0, 1)));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // sampled on the falling edge so queue and valid are settled
        while (tick_q.size() != 0 || s_valid) @(negedge aclk);
        while (pin_expect_q.size() != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
